// File: sv/lvm_pkg.sv
// ============================================================================
// lvm_pkg
// Shared types and constants for the LED level meter with peak hold.
// ============================================================================
package lvm_pkg;

    // fixed field widths
    localparam int SAMPLE_W  = 16;
    localparam int GAIN_W    = 10;
    localparam int STEP_CFG_W = 18;
    localparam int FALL_W    = 20;
    localparam int LED_W     = 6;
    localparam int LIT_W     = 7;
    localparam int VALUE_W   = 16;
    localparam int CFG_W     = 18;
    localparam int CFG_IDX_W = 3;
    localparam int OUT_TDATA_W = 32;

    // divider: (index + delta) * 0xFFFF needs 23 bits
    localparam int DIV_NUM_W = 23;

    localparam logic [VALUE_W-1:0] VALUE_MAX = 16'hFFFF;
    localparam logic [FALL_W-1:0]  FALL_CAP  = 20'hFFFFF;
    localparam int LEVEL_SHIFT = 17;

    // register reset values
    localparam logic [GAIN_W-1:0]     GAIN_RST       = 10'd1;
    localparam logic [STEP_CFG_W-1:0] BAR_FADE_RST   = 18'd4096;
    localparam logic [STEP_CFG_W-1:0] PEAK_START_RST = 18'd176;
    localparam logic [STEP_CFG_W-1:0] PEAK_ACCEL_RST = 18'd26;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_MODE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_MODE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BAR_FADE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_START   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_ACCEL   = 3'd5;

    // display modes
    localparam logic [1:0] DISP_MIN_SAME = 2'd1;
    localparam logic [1:0] DISP_MAX_SAME = 2'd2;

    // peak modes
    localparam logic [2:0] PEAK_NONE   = 3'd0;
    localparam logic [2:0] PEAK_MAX    = 3'd1;
    localparam logic [2:0] PEAK_HELD   = 3'd3;
    localparam logic [2:0] PEAK_MOVING = 3'd4;

    typedef struct packed {
        logic [GAIN_W-1:0]     gain;
        logic [1:0]            display_mode;
        logic [2:0]            peak_mode;
        logic [STEP_CFG_W-1:0] bar_fade_step;
        logic [STEP_CFG_W-1:0] peak_fade_start;
        logic [STEP_CFG_W-1:0] peak_fade_accel;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LEVEL,
        ST_BAR,
        ST_SETUP,
        ST_LED_GO,
        ST_LED,
        ST_PK_COLOUR,
        ST_PK_DIV,
        ST_PK_MOVE,
        ST_PK_EMIT
    } state_t;

endpackage

// File: sv/lvm_div.sv
// ============================================================================
// lvm_div
// Restoring divider, one quotient bit per cycle.
// ============================================================================
module lvm_div #(
    parameter int NUM_W = 23,
    parameter int DEN_W = 6
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             take;

    // one shift-subtract step
    always_comb begin
        trial = {rem_reg, quo_reg[NUM_W-1]};
        diff  = trial - {1'b0, den_reg};
        take  = (trial >= {1'b0, den_reg});
    end

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start) begin
            quo_next  = num;
            rem_next  = '0;
            den_next  = den;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
            done_next = 1'b0;
        end else if (busy_reg) begin
            quo_next = {quo_reg[NUM_W-2:0], take};
            rem_next = take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// File: sv/lvm_core.sv
// ============================================================================
// lvm_core
// Frame sequencer: level, bar fall, per-LED gradient and peak marker.
// ============================================================================
module lvm_core #(
    parameter int LED_COUNT     = 48,
    parameter int POS_FRAC_BITS = 12
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [lvm_pkg::SAMPLE_W-1:0]        peak,
    input  lvm_pkg::cfg_t                       cfg,
    output logic                                idle,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [lvm_pkg::OUT_TDATA_W-1:0]     m_tdata,  // led_index, led_value, lit_count
    output logic                                m_tlast,
    output logic [0:0]                          m_tuser   // kind
);
    localparam int PW      = POS_FRAC_BITS + 8;
    localparam int TW      = ((PW > 21) ? PW : 21) + 1;
    localparam int LED_MAX = LED_COUNT - 1;
    localparam int NW      = lvm_pkg::DIV_NUM_W;
    localparam int LW      = lvm_pkg::LED_W;
    localparam int CW      = PW + 16;
    localparam int LIT_W_C = lvm_pkg::LIT_W;

    localparam logic signed [PW-1:0] POS_ONE  = PW'(64'd1 << POS_FRAC_BITS);
    localparam logic signed [PW-1:0] POS_HALF = PW'(64'd1 << (POS_FRAC_BITS - 1));
    localparam logic signed [PW-1:0] POS_TOP  = PW'(64'(LED_MAX) << POS_FRAC_BITS);

    lvm_pkg::state_t state_reg, state_next;

    logic [25:0]                   mul_reg, mul_next;
    logic signed [6:0]             level_reg, level_next;
    logic signed [PW-1:0]          bar_reg, bar_next;
    logic signed [PW-1:0]          marker_reg, marker_next;
    logic [lvm_pkg::FALL_W-1:0]    step_reg, step_next;
    logic [15:0]                   colour_reg, colour_next;
    logic [15:0]                   col_tmp_reg, col_tmp_next;
    logic                          held_reg, held_next;
    logic [lvm_pkg::LIT_W-1:0]     lit_reg, lit_next;
    logic [LW-1:0]                 delta_reg, delta_next;
    logic [LW-1:0]                 den_reg, den_next;
    logic [LW-1:0]                 idx_reg, idx_next;

    logic                          ov_reg, ov_next;
    logic                          okind_reg, okind_next;
    logic [LW-1:0]                 oidx_reg, oidx_next;
    logic [15:0]                   oval_reg, oval_next;
    logic [lvm_pkg::LIT_W-1:0]     olit_reg, olit_next;
    logic                          olast_reg, olast_next;

    // divider
    logic            div_start;
    logic [NW-1:0]   div_num;
    logic [LW-1:0]   div_den;
    logic            div_done;
    logic [NW-1:0]   div_quo;

    lvm_div #(
        .NUM_W (NW),
        .DEN_W (LW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    // datapath helpers
    logic [31:0]           scaled;
    logic [14:0]           lvl_raw;
    logic signed [TW-1:0]  bar_sub;
    logic signed [PW-1:0]  bar_fall;
    logic signed [PW-1:0]  lvl_pos;
    logic [LW-1:0]         bar_int;
    logic signed [PW-1:0]  top_gap;
    logic [LIT_W_C-1:0]    led_n;
    logic [NW-1:0]         led_num;
    logic signed [PW-1:0]  col_pos;
    logic [CW-1:0]         col_prod;
    logic signed [TW-1:0]  mk_sub;
    logic signed [PW-1:0]  mk_round;
    logic [LW-1:0]         mk_led;
    logic [lvm_pkg::FALL_W:0] step_sum;
    logic                  out_free;
    logic                  peak_on;
    logic [15:0]           led_val;

    always_comb begin
        scaled   = 32'(mul_reg) * 32'(LED_COUNT);
        lvl_raw  = scaled[31:lvm_pkg::LEVEL_SHIFT];
        bar_sub  = TW'(bar_reg) - $signed(TW'(cfg.bar_fade_step));
        bar_fall = (bar_sub < TW'(-POS_ONE)) ? -POS_ONE : PW'(bar_sub);
        lvl_pos  = PW'(level_reg) <<< POS_FRAC_BITS;
        bar_int  = bar_reg[POS_FRAC_BITS +: LW];
        top_gap  = (POS_TOP - bar_reg) >>> POS_FRAC_BITS;
        led_n    = LIT_W_C'(idx_reg) + LIT_W_C'(delta_reg);
        led_num  = (NW'(led_n) << 16) - NW'(led_n);
        // colour position, clamped to the top LED
        col_pos  = (state_reg == lvm_pkg::ST_PK_COLOUR &&
                    cfg.peak_mode == lvm_pkg::PEAK_MOVING) ? marker_reg : bar_reg;
        if (col_pos > POS_TOP) begin
            col_pos = POS_TOP;
        end
        col_prod = (CW'(col_pos) << 16) - CW'(col_pos);
        mk_sub   = TW'(marker_reg) - $signed(TW'(step_reg));
        mk_round = marker_reg + POS_HALF;
        mk_led   = mk_round[PW-1] ? '0 : mk_round[POS_FRAC_BITS +: LW];
        if (!bar_reg[PW-1] && ((PW'(mk_led) << POS_FRAC_BITS) == bar_reg) &&
            (bar_reg < POS_TOP)) begin
            mk_led = mk_led + 1'b1;
        end
        step_sum = (lvm_pkg::FALL_W + 1)'(step_reg) +
                   (lvm_pkg::FALL_W + 1)'(cfg.peak_fade_accel);
        out_free = !ov_reg || m_tready;
        peak_on  = (cfg.peak_mode != lvm_pkg::PEAK_NONE);
        led_val  = (div_quo > NW'(lvm_pkg::VALUE_MAX)) ? lvm_pkg::VALUE_MAX : div_quo[15:0];
    end

    // sequencer
    always_comb begin
        state_next   = state_reg;
        mul_next     = mul_reg;
        level_next   = level_reg;
        bar_next     = bar_reg;
        marker_next  = marker_reg;
        step_next    = step_reg;
        colour_next  = colour_reg;
        col_tmp_next = col_tmp_reg;
        held_next    = held_reg;
        lit_next     = lit_reg;
        delta_next   = delta_reg;
        den_next     = den_reg;
        idx_next     = idx_reg;
        ov_next      = ov_reg && !m_tready;
        okind_next   = okind_reg;
        oidx_next    = oidx_reg;
        oval_next    = oval_reg;
        olit_next    = olit_reg;
        olast_next   = olast_reg;
        div_start    = 1'b0;
        div_num      = led_num;
        div_den      = den_reg;

        case (state_reg)
            lvm_pkg::ST_IDLE: begin
                if (start) begin
                    mul_next   = 26'(peak) * 26'(cfg.gain);
                    state_next = lvm_pkg::ST_LEVEL;
                end
            end
            lvm_pkg::ST_LEVEL: begin
                if (lvl_raw > 15'(LED_MAX)) begin
                    level_next = 7'(LED_MAX);
                end else if (lvl_raw == '0) begin
                    level_next = -7'sd1;
                end else begin
                    level_next = 7'(lvl_raw);
                end
                state_next = lvm_pkg::ST_BAR;
            end
            lvm_pkg::ST_BAR: begin
                bar_next   = (lvl_pos > bar_fall) ? lvl_pos : bar_fall;
                state_next = lvm_pkg::ST_SETUP;
            end
            lvm_pkg::ST_SETUP: begin
                idx_next   = '0;
                delta_next = '0;
                lit_next   = bar_reg[PW-1] ? '0 : LIT_W_C'(bar_int) + 1'b1;
                case (cfg.display_mode)
                    lvm_pkg::DISP_MIN_SAME: begin
                        den_next = LW'(LED_MAX);
                    end
                    lvm_pkg::DISP_MAX_SAME: begin
                        den_next = LW'(LED_MAX);
                        if (!bar_reg[PW-1]) begin
                            delta_next = top_gap[LW-1:0];
                        end
                    end
                    default: begin
                        den_next = bar_reg[PW-1] ? '0 : bar_int;
                    end
                endcase
                if (den_next == '0) begin
                    den_next = LW'(1);
                end
                if (bar_reg[PW-1]) begin
                    state_next = peak_on ? lvm_pkg::ST_PK_COLOUR : lvm_pkg::ST_IDLE;
                end else begin
                    state_next = lvm_pkg::ST_LED_GO;
                end
            end
            lvm_pkg::ST_LED_GO: begin
                div_start  = 1'b1;
                state_next = lvm_pkg::ST_LED;
            end
            lvm_pkg::ST_LED: begin
                if (div_done && out_free) begin
                    ov_next    = 1'b1;
                    okind_next = 1'b0;
                    oidx_next  = idx_reg;
                    oval_next  = led_val;
                    olit_next  = lit_reg;
                    olast_next = !peak_on && (LIT_W_C'(idx_reg) + 1'b1 == lit_reg);
                    if (LIT_W_C'(idx_reg) + 1'b1 == lit_reg) begin
                        state_next = peak_on ? lvm_pkg::ST_PK_COLOUR : lvm_pkg::ST_IDLE;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = lvm_pkg::ST_LED_GO;
                    end
                end
            end
            lvm_pkg::ST_PK_COLOUR: begin
                held_next  = (cfg.peak_mode == lvm_pkg::PEAK_HELD);
                state_next = lvm_pkg::ST_PK_MOVE;
                case (cfg.peak_mode)
                    lvm_pkg::PEAK_MAX: begin
                        col_tmp_next = lvm_pkg::VALUE_MAX;
                    end
                    lvm_pkg::PEAK_HELD, lvm_pkg::PEAK_MOVING: begin
                        col_tmp_next = '0;
                        if (col_pos > 0) begin
                            div_start  = 1'b1;
                            div_num    = NW'(col_prod >> POS_FRAC_BITS);
                            div_den    = LW'(LED_MAX);
                            state_next = lvm_pkg::ST_PK_DIV;
                        end
                    end
                    default: begin
                        col_tmp_next = '0;
                    end
                endcase
            end
            lvm_pkg::ST_PK_DIV: begin
                if (div_done) begin
                    col_tmp_next = div_quo[15:0];
                    state_next   = lvm_pkg::ST_PK_MOVE;
                end
            end
            lvm_pkg::ST_PK_MOVE: begin
                // fall, then re-seat on the bar when it has overtaken the marker
                if (TW'(bar_reg) > mk_sub) begin
                    step_next   = lvm_pkg::FALL_W'(cfg.peak_fade_start);
                    marker_next = bar_reg;
                    colour_next = col_tmp_reg;
                end else begin
                    marker_next = (mk_sub < TW'(-POS_ONE)) ? -POS_ONE : PW'(mk_sub);
                end
                if (!held_reg) begin
                    colour_next = col_tmp_reg;
                end
                state_next = lvm_pkg::ST_PK_EMIT;
            end
            lvm_pkg::ST_PK_EMIT: begin
                if (out_free) begin
                    ov_next    = 1'b1;
                    okind_next = 1'b1;
                    oidx_next  = mk_led;
                    oval_next  = colour_reg;
                    olit_next  = lit_reg;
                    olast_next = 1'b1;
                    step_next  = step_sum[lvm_pkg::FALL_W] ? lvm_pkg::FALL_CAP
                                                           : step_sum[lvm_pkg::FALL_W-1:0];
                    state_next = lvm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lvm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= lvm_pkg::ST_IDLE;
            bar_reg    <= -POS_ONE;
            marker_reg <= '0;
            step_reg   <= lvm_pkg::FALL_W'(lvm_pkg::PEAK_START_RST);
            colour_reg <= '0;
            ov_reg     <= 1'b0;
        end else begin
            state_reg  <= state_next;
            bar_reg    <= bar_next;
            marker_reg <= marker_next;
            step_reg   <= step_next;
            colour_reg <= colour_next;
            ov_reg     <= ov_next;
        end
        mul_reg     <= mul_next;
        level_reg   <= level_next;
        col_tmp_reg <= col_tmp_next;
        held_reg    <= held_next;
        lit_reg     <= lit_next;
        delta_reg   <= delta_next;
        den_reg     <= den_next;
        idx_reg     <= idx_next;
        okind_reg   <= okind_next;
        oidx_reg    <= oidx_next;
        oval_reg    <= oval_next;
        olit_reg    <= olit_next;
        olast_reg   <= olast_next;
    end

    assign idle     = (state_reg == lvm_pkg::ST_IDLE);
    assign m_tvalid = ov_reg;
    assign m_tdata  = {3'b000, olit_reg, oval_reg, oidx_reg};
    assign m_tlast  = olast_reg;
    assign m_tuser  = okind_reg;

endmodule

// File: sv/led_level_meter_peak_hold_top.sv
// ============================================================================
// led_level_meter_peak_hold_top
// LED level meter with falling bar and accelerating peak marker.
// ============================================================================
// A sample with tlast ends the frame and starts the display run: level and
// bar, then each lit LED's gradient value from the one-bit-per-cycle divider
// shared by all gradient and colour divisions, then the peak marker;
// s_tready is low throughout, and a stalled m_tready stretches it.
module led_level_meter_peak_hold_top #(
    parameter int LED_COUNT     = 48,
    parameter int POS_FRAC_BITS = 12
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [lvm_pkg::SAMPLE_W-1:0]         s_tdata,   // sample
    input  logic                                 s_tlast,   // frame_end
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [lvm_pkg::OUT_TDATA_W-1:0]      m_tdata,   // led_index, led_value, lit_count
    output logic                                 m_tlast,   // last
    output logic [0:0]                           m_tuser,   // kind
    input  logic                                 cfg_wr_en,
    input  logic [lvm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [lvm_pkg::CFG_W-1:0]            cfg_wdata
);
    lvm_pkg::cfg_t                 cfg_reg;
    logic [lvm_pkg::SAMPLE_W-1:0]  frame_peak_reg, frame_peak_next;
    logic [lvm_pkg::SAMPLE_W-1:0]  mag;
    logic [lvm_pkg::SAMPLE_W-1:0]  peak_now;
    logic                          accept;
    logic                          core_idle;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain            <= lvm_pkg::GAIN_RST;
            cfg_reg.display_mode    <= '0;
            cfg_reg.peak_mode       <= '0;
            cfg_reg.bar_fade_step   <= lvm_pkg::BAR_FADE_RST;
            cfg_reg.peak_fade_start <= lvm_pkg::PEAK_START_RST;
            cfg_reg.peak_fade_accel <= lvm_pkg::PEAK_ACCEL_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                lvm_pkg::REG_GAIN:         cfg_reg.gain <= cfg_wdata[lvm_pkg::GAIN_W-1:0];
                lvm_pkg::REG_DISPLAY_MODE: cfg_reg.display_mode <= cfg_wdata[1:0];
                lvm_pkg::REG_PEAK_MODE:    cfg_reg.peak_mode <= cfg_wdata[2:0];
                lvm_pkg::REG_BAR_FADE:     cfg_reg.bar_fade_step <= cfg_wdata;
                lvm_pkg::REG_PEAK_START:   cfg_reg.peak_fade_start <= cfg_wdata;
                lvm_pkg::REG_PEAK_ACCEL:   cfg_reg.peak_fade_accel <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // frame peak magnitude tracking
    always_comb begin
        accept   = s_tvalid && s_tready;
        mag      = s_tdata[lvm_pkg::SAMPLE_W-1] ? (~s_tdata + 1'b1) : s_tdata;
        peak_now = (mag > frame_peak_reg) ? mag : frame_peak_reg;
        frame_peak_next = frame_peak_reg;
        if (accept) begin
            frame_peak_next = s_tlast ? '0 : peak_now;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_peak_reg <= '0;
        end else begin
            frame_peak_reg <= frame_peak_next;
        end
    end

    assign s_tready = core_idle;

    lvm_core #(
        .LED_COUNT     (LED_COUNT),
        .POS_FRAC_BITS (POS_FRAC_BITS)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (accept && s_tlast),
        .peak     (peak_now),
        .cfg      (cfg_reg),
        .idle     (core_idle),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
